[src/concat_string_bit_lookup_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the concatenated string bit lookup unit
// Immediate-implication and next-cycle forms, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef CONCAT_STRING_BIT_LOOKUP_UNIT_DEFINES_SVH
`define CONCAT_STRING_BIT_LOOKUP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CSBL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CSBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CSBL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CSBL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/csbl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csbl_pkg
// Shared types and constants of the concatenated string bit lookup unit.
// ----------------------------------------------------------------------------
package csbl_pkg;

    localparam int MAX_NODES_DEF   = 1024;
    localparam int LIFT_LEVELS_DEF = 11;
    localparam int LEN_W           = 61;
    localparam int POS_W           = 60;
    localparam int IDX_W           = 10;

    localparam logic [LEN_W-1:0] LEFT_CAP = 61'd1000000000000000000;
    localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] LEAF_LEN = 61'd1;

    typedef struct packed {
        logic [IDX_W-1:0] left_child;
        logic [IDX_W-1:0] right_child;
        logic [POS_W-1:0] position;
    } t_cmd;

    typedef struct packed {
        logic bit_value;
        logic position_error;
    } t_result;

    // saturating length add
    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
    endfunction

endpackage

[src/concat_string_bit_lookup_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// concat_string_bit_lookup_unit
// Builds concatenation nodes with heavy-path lifting tables and answers the
// bit at a position of each new node.
// ----------------------------------------------------------------------------
// channel  | direction | handshake            | payload
// command  | in        | i_start & !o_busy    | i_cmd    (t_cmd)
// result   | out       | o_done, one cycle    | o_result (t_result)
//
// Steps: an item reads both child lengths, writes the node and its level 0
// jump, fills the higher jump levels, checks the position, then per descent
// round walks the jump levels from the top down and steps to a child; each
// step is bound by the single read port of the node or jump memory.
// A full table answers in the next cycle. o_busy is high until the result strobe.
// Reset: synchronous, active low; memories are not cleared (leaf entries are
// produced by logic, every other entry is written before it is read).
// The result cannot be stalled: o_done is high for exactly one cycle.
// ----------------------------------------------------------------------------
`include "concat_string_bit_lookup_unit_defines.svh"

module concat_string_bit_lookup_unit #(
    parameter int MAX_NODES   = csbl_pkg::MAX_NODES_DEF,
    parameter int LIFT_LEVELS = csbl_pkg::LIFT_LEVELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  csbl_pkg::t_cmd    i_cmd,
    output logic              o_busy,
    output logic              o_done,
    output csbl_pkg::t_result o_result
);
    import csbl_pkg::*;

    localparam int NW = $clog2(MAX_NODES);               // node index
    localparam int CW = NW + 1;                          // node count
    localparam int JD = MAX_NODES * LIFT_LEVELS;
    localparam int JW = $clog2(JD);                      // jump address
    localparam int LW = $clog2(LIFT_LEVELS);             // level index
    localparam logic [LW-1:0] LVL_TOP = LW'(LIFT_LEVELS - 1);

    // node entry: children and length
    typedef struct packed {
        logic [NW-1:0]    left;
        logic [NW-1:0]    right;
        logic [LEN_W-1:0] len;
    } t_node;

    // lifting entry: valid marks a real target
    typedef struct packed {
        logic             valid;
        logic [NW-1:0]    tgt;
        logic [LEN_W-1:0] off;
    } t_jump;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RDL   = 13'b0000000000010,
        S_RDR   = 13'b0000000000100,
        S_MK    = 13'b0000000001000,
        S_JRD   = 13'b0000000010000,
        S_JWR   = 13'b0000000100000,
        S_QS    = 13'b0000001000000,
        S_QJRD  = 13'b0000010000000,
        S_QJCHK = 13'b0000100000000,
        S_QJLEN = 13'b0001000000000,
        S_QCRD  = 13'b0010000000000,
        S_QCDAT = 13'b0100000000000,
        S_QCLEN = 13'b1000000000000
    } t_state;

    // memories
    t_node r_nmem [MAX_NODES];
    t_jump r_jmem [JD];
    t_node r_nq;
    t_jump r_jq;

    logic [NW-1:0] n_nraddr;
    logic          n_nwe;
    logic [NW-1:0] n_nwaddr;
    t_node         n_nwdata;
    logic [JW-1:0] n_jraddr;
    logic          n_jwe;
    logic [JW-1:0] n_jwaddr;
    t_jump         n_jwdata;

    always_ff @(posedge i_clk) begin
        if (n_nwe) begin
            r_nmem[n_nwaddr] <= n_nwdata;
        end
        r_nq <= r_nmem[n_nraddr];
    end

    always_ff @(posedge i_clk) begin
        if (n_jwe) begin
            r_jmem[n_jwaddr] <= n_jwdata;
        end
        r_jq <= r_jmem[n_jraddr];
    end

    // control and working registers
    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_done, n_done;
    t_result          r_res, n_res;
    logic [NW-1:0]    r_l, n_l, r_r, n_r, r_u, n_u;
    logic [NW-1:0]    r_cur, n_cur, r_v, n_v;
    logic [LEN_W-1:0] r_lenl, n_lenl, r_lenu, n_lenu, r_off, n_off;
    logic [POS_W-1:0] r_x, n_x;
    logic [LW-1:0]    r_lvl, n_lvl;
    t_jump            r_prev, n_prev;

    logic [LEN_W-1:0] w_lenr, w_lenv, w_xl;
    logic [NW-1:0]    w_r;
    t_jump            w_ent;

    function automatic logic [JW-1:0] jaddr(input logic [NW-1:0] n,
                                            input logic [LW-1:0] lv);
        return JW'(JW'(n) * JW'(LIFT_LEVELS) + JW'(lv));
    endfunction

    assign w_xl = {1'b0, r_x};

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_done   = 1'b0;
        n_res    = r_res;
        n_l      = r_l;
        n_r      = r_r;
        n_u      = r_u;
        n_cur    = r_cur;
        n_v      = r_v;
        n_lenl   = r_lenl;
        n_lenu   = r_lenu;
        n_off    = r_off;
        n_x      = r_x;
        n_lvl    = r_lvl;
        n_prev   = r_prev;
        n_nraddr = r_l;
        n_nwe    = 1'b0;
        n_nwaddr = r_u;
        n_nwdata = '0;
        n_jraddr = jaddr(r_cur, r_lvl);
        n_jwe    = 1'b0;
        n_jwaddr = jaddr(r_u, r_lvl);
        n_jwdata = '0;
        w_lenr   = LEAF_LEN;
        w_lenv   = LEAF_LEN;
        w_r      = r_r;
        w_ent    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (r_count >= CW'(MAX_NODES)) begin
                        n_done = 1'b1;
                        n_res  = '{bit_value: 1'b0, position_error: 1'b1};
                    end else begin
                        // undefined children fall back to leaf 0
                        n_l   = (32'(i_cmd.left_child) >= 32'(r_count)) ? '0
                                : NW'(i_cmd.left_child);
                        n_r   = (32'(i_cmd.right_child) >= 32'(r_count)) ? '0
                                : NW'(i_cmd.right_child);
                        n_u   = r_count[NW-1:0];
                        n_x   = i_cmd.position;
                        n_state = S_RDL;
                    end
                end
            end
            S_RDL: begin
                n_nraddr = r_l;
                n_state  = S_RDR;
            end
            S_RDR: begin
                n_nraddr = r_r;
                n_lenl   = (r_l < NW'(2)) ? LEAF_LEN : r_nq.len;
                n_state  = S_MK;
            end
            S_MK: begin
                w_lenr = (r_r < NW'(2)) ? LEAF_LEN : r_nq.len;
                w_r    = r_r;
                if (r_lenl >= LEFT_CAP) begin
                    w_r    = '0;
                    w_lenr = LEAF_LEN;
                end
                n_lenu   = sat_add(r_lenl, w_lenr);
                n_nwe    = 1'b1;
                n_nwaddr = r_u;
                n_nwdata = '{left: r_l, right: w_r, len: sat_add(r_lenl, w_lenr)};
                if (r_lenl > w_lenr) begin
                    w_ent = '{valid: 1'b1, tgt: r_l, off: '0};
                end else begin
                    w_ent = '{valid: 1'b1, tgt: w_r, off: r_lenl};
                end
                n_jwe    = 1'b1;
                n_jwaddr = jaddr(r_u, '0);
                n_jwdata = w_ent;
                n_prev   = w_ent;
                n_lvl    = LW'(1);
                n_state  = S_JRD;
            end
            S_JRD: begin
                if (!r_prev.valid || r_prev.tgt < NW'(2)) begin
                    // no further jump: target none, offset carried
                    w_ent    = '{valid: 1'b0, tgt: '0, off: r_prev.off};
                    n_jwe    = 1'b1;
                    n_jwaddr = jaddr(r_u, r_lvl);
                    n_jwdata = w_ent;
                    n_prev   = w_ent;
                    n_lvl    = r_lvl + LW'(1);
                    n_state  = (r_lvl == LVL_TOP) ? S_QS : S_JRD;
                end else begin
                    n_jraddr = jaddr(r_prev.tgt, r_lvl - LW'(1));
                    n_state  = S_JWR;
                end
            end
            S_JWR: begin
                w_ent    = '{valid: r_jq.valid, tgt: r_jq.tgt,
                             off: sat_add(r_jq.off, r_prev.off)};
                n_jwe    = 1'b1;
                n_jwaddr = jaddr(r_u, r_lvl);
                n_jwdata = w_ent;
                n_prev   = w_ent;
                n_lvl    = r_lvl + LW'(1);
                n_state  = (r_lvl == LVL_TOP) ? S_QS : S_JRD;
            end
            S_QS: begin
                n_count = r_count + CW'(1);
                if (r_x == '0 || w_xl > r_lenu) begin
                    n_done  = 1'b1;
                    n_res   = '{bit_value: 1'b0, position_error: 1'b1};
                    n_state = S_IDLE;
                end else begin
                    n_cur   = r_u;
                    n_lvl   = LVL_TOP;
                    n_state = S_QJRD;
                end
            end
            S_QJRD: begin
                if (r_cur < NW'(2)) begin
                    n_done  = 1'b1;
                    n_res   = '{bit_value: r_cur[0], position_error: 1'b0};
                    n_state = S_IDLE;
                end else begin
                    n_jraddr = jaddr(r_cur, r_lvl);
                    n_state  = S_QJCHK;
                end
            end
            S_QJCHK: begin
                if (r_jq.valid) begin
                    n_v      = r_jq.tgt;
                    n_off    = r_jq.off;
                    n_nraddr = r_jq.tgt;
                    n_state  = S_QJLEN;
                end else begin
                    n_lvl   = r_lvl - LW'(1);
                    n_state = (r_lvl == '0) ? S_QCRD : S_QJRD;
                end
            end
            S_QJLEN: begin
                w_lenv = (r_v < NW'(2)) ? LEAF_LEN : r_nq.len;
                if (w_xl > r_off && (w_xl - r_off) <= w_lenv) begin
                    n_x   = POS_W'(w_xl - r_off);
                    n_cur = r_v;
                end
                n_lvl   = r_lvl - LW'(1);
                n_state = (r_lvl == '0) ? S_QCRD : S_QJRD;
            end
            S_QCRD: begin
                if (r_cur < NW'(2)) begin
                    n_done  = 1'b1;
                    n_res   = '{bit_value: r_cur[0], position_error: 1'b0};
                    n_state = S_IDLE;
                end else begin
                    n_nraddr = r_cur;
                    n_state  = S_QCDAT;
                end
            end
            S_QCDAT: begin
                n_l      = r_nq.left;
                n_r      = r_nq.right;
                n_nraddr = r_nq.left;
                n_state  = S_QCLEN;
            end
            S_QCLEN: begin
                w_lenv = (r_l < NW'(2)) ? LEAF_LEN : r_nq.len;
                if (w_lenv >= w_xl) begin
                    n_cur = r_l;
                end else begin
                    n_x   = POS_W'(w_xl - w_lenv);
                    n_cur = r_r;
                end
                n_lvl   = LVL_TOP;
                n_state = S_QJRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CW'(2);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_l    <= n_l;
        r_r    <= n_r;
        r_u    <= n_u;
        r_cur  <= n_cur;
        r_v    <= n_v;
        r_lenl <= n_lenl;
        r_lenu <= n_lenu;
        r_off  <= n_off;
        r_x    <= n_x;
        r_lvl  <= n_lvl;
        r_prev <= n_prev;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // a result always lands back in idle
    `CSBL_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)
    // an accepted item either runs or answers at once
    `CSBL_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, i_start && !o_busy, o_busy || o_done)
    // node count never passes the table size
    `CSBL_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_NODES))

endmodule
